// File: design/fps_pkg.sv
`timescale 1ns / 1ps

package fps_pkg;

    localparam int TABLE_SIZE_DEF = 1024;
    localparam int IDX_W          = 10;
    localparam int DELTA_W        = 32;
    localparam int SUM_W          = 64;

    // command codes
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // command handed from the front end to the walk sequencer
    typedef struct packed {
        logic                       cmd;
        logic [IDX_W-1:0]           index;
        logic signed [DELTA_W-1:0]  delta;
    } walk_req_t;

    // sequencer status seen by the front end
    typedef struct packed {
        logic idle;
        logic done;
    } walk_stat_t;

endpackage

// File: design/fenwick_prefix_sum_tree.sv
`timescale 1ns / 1ps
// a query word passes from acceptance through S_WALK, which sums its nodes, and S_FINISH
// into the output register; a walk visits at most log2(TABLE_SIZE) nodes for an add and at
// most IDX_W for a query, paced by the single read and single write port of the node store,
// one node per cycle through the shared 64-bit adder; a new word waits until the last is done
// reset: rst_n asynchronous active low; afterwards a clearing pass zeroes all TABLE_SIZE
// entries of the store, and no input word is taken until it ends

module fenwick_prefix_sum_tree #(
    parameter int TABLE_SIZE = fps_pkg::TABLE_SIZE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // command channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               cmd,
    input  logic [fps_pkg::IDX_W-1:0]          index,
    input  logic signed [fps_pkg::DELTA_W-1:0] delta,
    // result channel, one word per query
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [fps_pkg::SUM_W-1:0]   prefix_sum
);
    import fps_pkg::*;

    walk_req_t        req;
    walk_stat_t       stat;
    logic             start;
    logic             out_free;
    logic [SUM_W-1:0] walk_sum;

    logic             out_valid_reg;
    logic [SUM_W-1:0] prefix_sum_reg;

    // the sequencer takes a word only when idle (not clearing, not walking)
    assign in_stall = !stat.idle;
    assign start    = in_valid && stat.idle;

    assign req.cmd   = cmd;
    assign req.index = index;
    assign req.delta = delta;

    // output slot is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || !out_stall;

    fps_walk #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_walk (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (req),
        .out_free (out_free),
        .stat     (stat),
        .sum_out  (walk_sum)
    );

    // output register parts the result side from the walk
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stat.done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.done)
        begin
            prefix_sum_reg <= walk_sum;
        end
    end

    assign out_valid  = out_valid_reg;
    assign prefix_sum = prefix_sum_reg;

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !stat.done)
        else $error("result overwritten");

    // a word is only taken by an idle sequencer
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !stat.idle)
        else $error("sequencer did not leave idle");

    // a delivered word is followed by the register emptying unless refilled
    a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !stat.done) |=> !out_valid_reg)
        else $error("output word repeated");

endmodule

// File: design/fps_mem.sv
`timescale 1ns / 1ps

module fps_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                    clk,
    input  logic                    we,
    input  logic [AW-1:0]           waddr,
    input  logic [fps_pkg::SUM_W-1:0] wdata,
    input  logic                    re,
    input  logic [AW-1:0]           raddr,
    output logic [fps_pkg::SUM_W-1:0] rdata
);
    import fps_pkg::*;

    logic [SUM_W-1:0] mem [DEPTH];
    logic [SUM_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/fps_walk.sv
`timescale 1ns / 1ps

module fps_walk #(
    parameter int TABLE_SIZE = fps_pkg::TABLE_SIZE_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  fps_pkg::walk_req_t        req,
    input  logic                      out_free,
    output fps_pkg::walk_stat_t       stat,
    output logic [fps_pkg::SUM_W-1:0] sum_out
);
    import fps_pkg::*;

    localparam int AW    = $clog2(TABLE_SIZE);
    localparam int POS_W = ((AW > IDX_W) ? AW : IDX_W) + 1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_FINISH
    } state_t;

    state_t             state_reg, state_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               cmd_reg, cmd_next;
    logic [SUM_W-1:0]   delta_reg, delta_next;
    logic [SUM_W-1:0]   acc_reg, acc_next;
    logic               pend_vld_reg, pend_vld_next;
    logic [AW-1:0]      pend_addr_reg, pend_addr_next;
    logic [AW-1:0]      clr_reg, clr_next;

    logic [POS_W-1:0]   low_bit;
    logic               in_range;
    logic               cont;
    logic [SUM_W-1:0]   add_a, add_b, add_sum;
    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    logic [SUM_W-1:0]   mem_wdata, mem_rdata;

    fps_mem #(
        .DEPTH (TABLE_SIZE),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign low_bit  = pos_reg & (~pos_reg + POS_W'(1));
    assign in_range = (pos_reg < POS_W'(TABLE_SIZE));
    // add stops at zero or at the table edge, query only at zero
    assign cont     = (pos_reg != '0) && (in_range || (cmd_reg == CMD_QUERY));

    // shared 64-bit adder: node update for add, accumulate for query
    assign add_a   = (cmd_reg == CMD_QUERY) ? acc_reg : mem_rdata;
    assign add_b   = (cmd_reg == CMD_QUERY) ? mem_rdata : delta_reg;
    assign add_sum = add_a + add_b;

    assign mem_re    = (state_reg == S_WALK) && cont && in_range;
    assign mem_raddr = pos_reg[AW-1:0];

    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = (state_reg == S_WALK) && pend_vld_reg && (cmd_reg == CMD_ADD);
            mem_waddr = pend_addr_reg;
            mem_wdata = add_sum;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        cmd_next       = cmd_reg;
        delta_next     = delta_reg;
        acc_next       = acc_reg;
        pend_vld_next  = pend_vld_reg;
        pend_addr_next = pend_addr_reg;
        clr_next       = clr_reg;

        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(TABLE_SIZE - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    pos_next      = POS_W'(req.index);
                    cmd_next      = req.cmd;
                    delta_next    = {{(SUM_W - DELTA_W){req.delta[DELTA_W-1]}}, req.delta};
                    acc_next      = '0;
                    pend_vld_next = 1'b0;
                    state_next    = S_WALK;
                end
            end
            S_WALK:
            begin
                // retire the node read last cycle
                if (pend_vld_reg && (cmd_reg == CMD_QUERY))
                begin
                    acc_next = add_sum;
                end
                // issue the next node of the walk
                if (cont)
                begin
                    pend_vld_next  = in_range;
                    pend_addr_next = pos_reg[AW-1:0];
                    pos_next       = (cmd_reg == CMD_ADD) ? (pos_reg + low_bit)
                                                          : (pos_reg - low_bit);
                end
                else
                begin
                    pend_vld_next = 1'b0;
                    state_next    = (cmd_reg == CMD_QUERY) ? S_FINISH : S_IDLE;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            pend_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pend_vld_reg  <= pend_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        cmd_reg       <= cmd_next;
        delta_reg     <= delta_next;
        acc_reg       <= acc_next;
        pend_addr_reg <= pend_addr_next;
    end

    assign stat.idle = (state_reg == S_IDLE);
    assign stat.done = (state_reg == S_FINISH) && out_free;
    assign sum_out   = acc_reg;

    // a pending node read only exists while walking
    a_pend_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        pend_vld_reg |-> (state_reg == S_WALK))
        else $error("pending read outside walk");

    // add walk climbs the tree, query walk descends it
    a_add_climbs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) && pend_vld_reg && (cmd_reg == CMD_ADD)
        |-> (pos_reg > POS_W'(pend_addr_reg)))
        else $error("add walk did not climb");

    a_query_descends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) && pend_vld_reg && (cmd_reg == CMD_QUERY)
        |-> (pos_reg < POS_W'(pend_addr_reg)))
        else $error("query walk did not descend");

    // store is written only by the clearing pass or an add walk
    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ((state_reg == S_CLEAR) ||
                    ((state_reg == S_WALK) && (cmd_reg == CMD_ADD))))
        else $error("unexpected store write");

    // a finished query is handed over only into a free output slot
    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |=> (state_reg == S_IDLE))
        else $error("finish did not return to idle");

endmodule
